@@ hw/rtl/can_bit_timing_search_top_macros.svh @@
// Assertion helpers for the CAN bit timing search block.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef CAN_BIT_TIMING_SEARCH_TOP_MACROS_SVH
`define CAN_BIT_TIMING_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CBTS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CBTS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cbts_pkg.sv @@
`timescale 1ns / 1ps

package cbts_pkg;

  // Default search limits.
  localparam int SEG1_MAX_DEF      = 16;
  localparam int SEG2_MAX_DEF      = 8;
  localparam int PRESCALER_MAX_DEF = 512;

  // Field widths of the channels.
  localparam int RATE_W = 20;
  localparam int PRE_W  = 10;
  localparam int S1C_W  = 4;
  localparam int S2C_W  = 3;
  localparam int SJW_W  = 2;

  // Clock register and shared divider widths.
  localparam int CLK_W = 32;
  localparam int DIV_W = 32;
  localparam int CNT_W = $clog2(DIV_W);

  // Sample point and rate tolerance constants.
  localparam int SPE_W          = 6;
  localparam int SP_TARGET      = 192;
  localparam int SP_TOLERANCE   = 38;
  localparam int RATE_TOL_SHIFT = 7;
  localparam int TOL_W          = RATE_W - RATE_TOL_SHIFT;
  localparam int SJW_MAX        = 4;
  localparam int SP_SHIFT       = 8;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CLK_W-1:0] CLK_RESET = 32'd36000000;

  // Register index decoded from paddr[2].
  localparam logic REG_PCLK = 1'b0;

endpackage

@@ hw/rtl/cbts_if.sv @@
`timescale 1ns / 1ps

// Request channel: one requested bit rate per request.
interface cbts_in_if;
  import cbts_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] bit_rate;

  modport source (output valid, output bit_rate, input ready);
  modport sink (input valid, input bit_rate, output ready);
endinterface

// Result channel: one timing solution per request.
interface cbts_out_if;
  import cbts_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [PRE_W-1:0] prescaler;
  logic [S1C_W-1:0] seg1_code;
  logic [S2C_W-1:0] seg2_code;
  logic [SJW_W-1:0] sjw_code;

  modport source (output valid, output found, output prescaler, output seg1_code,
                  output seg2_code, output sjw_code, input ready);
  modport sink (input valid, input found, input prescaler, input seg1_code,
                input seg2_code, input sjw_code, output ready);
endinterface

@@ hw/rtl/cbts_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module cbts_div #(
  parameter int DIVISOR_W = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cbts_pkg::DIV_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]       divisor,
  output logic                       done,
  output logic [cbts_pkg::DIV_W-1:0] quotient
);
  import cbts_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  logic                 running_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] divisor_r;
  logic [DIV_W-1:0]     quo_r;

  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;
  logic [DIVISOR_W-1:0] rem_step;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    diff     = shifted - {1'b0, divisor_r};
    fits     = (shifted >= {1'b0, divisor_r});
    rem_step = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
  end

  // Iteration control; the quotient builds up in place of the dividend.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
        rem_r     <= '0;
        quo_r     <= dividend;
        divisor_r <= divisor;
      end else if (running_r) begin
        rem_r <= rem_step;
        quo_r <= {quo_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hw/rtl/can_bit_timing_search_top.sv @@
`timescale 1ns / 1ps

// CAN bit timing search.
// A request on in_ch carries a bit rate; one result leaves on out_ch with a
// found flag and the prescaler, segment 1, segment 2 and SJW register codes
// (all zero when nothing fits or the rate is zero). The peripheral clock in
// hertz is written over the APB-style port at byte address 0 (pready is
// always high) and must only change while the block is idle.
// All divisions run on one shared restoring divider. Every segment pair costs
// one sample point division; a pair whose sample point is in range adds one
// prescaler estimate division and up to three rate checks, each with its own
// division. With the default limits there are 100 pairs, 76 of them in range;
// a zero rate skips the search and goes straight to the result.
// in_ch.ready is high only while idle.
// The result sits in an output register; if the receiver stalls, the block
// returns to idle and takes the next request, holding the following result
// until the previous one is taken.
// Reset returns the sequencer to idle, clears the output valid and loads
// the clock register with 36 MHz.
module can_bit_timing_search_top #(
  parameter int SEG1_MAX      = cbts_pkg::SEG1_MAX_DEF,
  parameter int SEG2_MAX      = cbts_pkg::SEG2_MAX_DEF,
  parameter int PRESCALER_MAX = cbts_pkg::PRESCALER_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cbts_in_if.sink                     in_ch,
  cbts_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbts_pkg::CFG_AW-1:0] paddr,
  input  logic [cbts_pkg::CFG_DW-1:0] pwdata,
  output logic [cbts_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import cbts_pkg::*;

  `include "can_bit_timing_search_top_macros.svh"

  localparam int SW   = $clog2(SEG1_MAX + SEG2_MAX + 2);
  localparam int P_W  = $clog2(PRESCALER_MAX + 1);
  localparam int DV_W = SW + RATE_W;

  localparam logic [SW-1:0]    S1_LAST   = SW'(SEG1_MAX);
  localparam logic [SW-1:0]    S2_LAST   = SW'(SEG2_MAX);
  localparam logic [SW-1:0]    SJW_LIM   = SW'(SJW_MAX);
  localparam logic [DIV_W-1:0] EST_LIM   = DIV_W'(PRESCALER_MAX + 1);
  localparam logic [DIV_W-1:0] PMAX_W    = DIV_W'(PRESCALER_MAX);
  localparam logic [P_W-1:0]   PMAX_P    = P_W'(PRESCALER_MAX);
  localparam logic [DIV_W-1:0] SP_TGT_W  = DIV_W'(SP_TARGET);
  localparam logic [DIV_W-1:0] SP_TOL_W  = DIV_W'(SP_TOLERANCE);

  typedef enum logic [3:0] {
    S_IDLE, S_PAIR, S_SPDIV, S_ESTGO, S_ESTDIV, S_PMUL, S_PDIV, S_PCHK, S_DONE
  } state_t;

  state_t              state_r;
  logic [CLK_W-1:0]    pclk_r;
  logic [RATE_W-1:0]   rate_r;
  logic [SW-1:0]       s1_r;
  logic [SW-1:0]       s2_r;
  logic [P_W-1:0]      p_r;
  logic [P_W-1:0]      hi_r;
  logic [SPE_W-1:0]    sperr_r;
  logic [DIV_W-1:0]    rerr_r;
  logic                have_r;
  logic [TOL_W-1:0]    best_rerr_r;
  logic [SPE_W-1:0]    best_sperr_r;
  logic [P_W-1:0]      sel_pre_r;
  logic [SW-1:0]       sel_s1_r;
  logic [SW-1:0]       sel_s2_r;
  logic                out_valid_r;
  logic                out_found_r;
  logic [PRE_W-1:0]    out_pre_r;
  logic [S1C_W-1:0]    out_s1_r;
  logic [S2C_W-1:0]    out_s2_r;
  logic [SJW_W-1:0]    out_sjw_r;

  logic [SW-1:0]       nq;
  logic [RATE_W-1:0]   mul_b;
  logic [DV_W-1:0]     mul_out;
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DV_W-1:0]     div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_q;
  logic [DIV_W-1:0]    sperr;
  logic [DIV_W-1:0]    rerr;
  logic [DIV_W-1:0]    rate_w;
  logic [TOL_W-1:0]    tol;
  logic                cand_ok;
  logic                cfg_wr;
  logic                in_req;
  logic                out_take;
  logic                res_hit;
  logic                res_miss;
  logic                res_zero;
  logic                seg_ok;
  logic                sjw_ok;

  // Quanta per bit, the shared multiplier and the divider operand select.
  always_comb begin
    nq           = s1_r + s2_r + SW'(1);
    mul_b        = (state_r == S_ESTGO) ? rate_r : RATE_W'(p_r);
    mul_out      = DV_W'(nq) * DV_W'(mul_b);
    div_start    = (state_r == S_PAIR && s1_r <= S1_LAST) ||
                   (state_r == S_ESTGO) || (state_r == S_PMUL);
    div_dividend = (state_r == S_PAIR) ? DIV_W'({s1_r + SW'(1), {SP_SHIFT{1'b0}}}) : pclk_r;
    div_divisor  = (state_r == S_PAIR) ? DV_W'(nq) : mul_out;
  end

  cbts_div #(
    .DIVISOR_W(DV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Error terms and the acceptance test of a prescaler candidate.
  always_comb begin
    rate_w  = DIV_W'(rate_r);
    sperr   = (div_q > SP_TGT_W) ? (div_q - SP_TGT_W) : (SP_TGT_W - div_q);
    rerr    = (div_q > rate_w) ? (div_q - rate_w) : (rate_w - div_q);
    tol     = TOL_W'(rate_r >> RATE_TOL_SHIFT);
    cand_ok = (rerr_r <= DIV_W'(tol)) &&
              (!have_r || ((sperr_r <= best_sperr_r) &&
                           (rerr_r <= DIV_W'(best_rerr_r))));
  end

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_req   = in_ch.valid && in_ch.ready;
  assign out_take = out_valid_r && out_ch.ready;

  // Search sequencer, clock register and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pclk_r      <= CLK_RESET;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_PCLK) begin
        pclk_r <= pwdata;
      end
      if (out_take && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_req) begin
            rate_r <= in_ch.bit_rate;
            have_r <= 1'b0;
            s2_r   <= SW'(1);
            s1_r   <= SW'(1);
            state_r <= (in_ch.bit_rate == '0) ? S_DONE : S_PAIR;
          end
        end
        // Once segment 1 runs past its limit, move to the next segment 2 or, after the last, finish.
        S_PAIR: begin
          if (s1_r > S1_LAST) begin
            if (s2_r == S2_LAST) begin
              state_r <= S_DONE;
            end else begin
              s2_r <= s2_r + SW'(1);
              s1_r <= s2_r + SW'(1);
            end
          end else begin
            state_r <= S_SPDIV;
          end
        end
        // Sample point check; a pair out of range is skipped whole.
        S_SPDIV: begin
          if (div_done) begin
            if (sperr > SP_TOL_W) begin
              s1_r    <= s1_r + SW'(1);
              state_r <= S_PAIR;
            end else begin
              sperr_r <= SPE_W'(sperr);
              state_r <= S_ESTGO;
            end
          end
        end
        S_ESTGO: begin
          state_r <= S_ESTDIV;
        end
        // Prescaler range around the estimate; a pair whose estimate exceeds PRESCALER_MAX + 1 is skipped.
        S_ESTDIV: begin
          if (div_done) begin
            if (div_q > EST_LIM) begin
              s1_r    <= s1_r + SW'(1);
              state_r <= S_PAIR;
            end else begin
              p_r     <= (div_q > DIV_W'(1)) ? P_W'(div_q - DIV_W'(1)) : P_W'(1);
              hi_r    <= (div_q < PMAX_W) ? P_W'(div_q + DIV_W'(1)) : PMAX_P;
              state_r <= S_PMUL;
            end
          end
        end
        S_PMUL: begin
          state_r <= S_PDIV;
        end
        S_PDIV: begin
          if (div_done) begin
            rerr_r  <= rerr;
            state_r <= S_PCHK;
          end
        end
        // Keep the candidate if its rate error is within tolerance and it is not worse in either error.
        S_PCHK: begin
          if (cand_ok) begin
            have_r       <= 1'b1;
            best_rerr_r  <= TOL_W'(rerr_r);
            best_sperr_r <= sperr_r;
            sel_pre_r    <= p_r;
            sel_s1_r     <= s1_r;
            sel_s2_r     <= s2_r;
          end
          if (p_r == hi_r) begin
            s1_r    <= s1_r + SW'(1);
            state_r <= S_PAIR;
          end else begin
            p_r     <= p_r + P_W'(1);
            state_r <= S_PMUL;
          end
        end
        // Load the result once the output register is free.
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= have_r;
            if (have_r) begin
              out_pre_r <= PRE_W'(sel_pre_r);
              out_s1_r  <= S1C_W'(sel_s1_r - SW'(1));
              out_s2_r  <= S2C_W'(sel_s2_r - SW'(1));
              out_sjw_r <= (sel_s2_r <= SJW_LIM) ? SJW_W'(sel_s2_r - SW'(1))
                                                 : SJW_W'(SJW_LIM - SW'(1));
            end else begin
              out_pre_r <= '0;
              out_s1_r  <= '0;
              out_s2_r  <= '0;
              out_sjw_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Channel and configuration outputs.
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.prescaler = out_pre_r;
  assign out_ch.seg1_code = out_s1_r;
  assign out_ch.seg2_code = out_s2_r;
  assign out_ch.sjw_code  = out_sjw_r;
  assign pready           = 1'b1;
  assign prdata           = (paddr[2] == REG_PCLK) ? pclk_r : '0;

  // Terms for the result checks below.
  assign res_hit  = out_ch.valid && out_ch.found;
  assign res_miss = out_ch.valid && !out_ch.found;
  assign res_zero = out_ch.prescaler == '0 && out_ch.seg1_code == '0 &&
                    out_ch.seg2_code == '0 && out_ch.sjw_code == '0;
  assign seg_ok   = out_ch.seg1_code >= S1C_W'(out_ch.seg2_code);
  assign sjw_ok   = (out_ch.seg2_code >= S2C_W'(SJW_MAX - 1))
                    ? (out_ch.sjw_code == SJW_W'(SJW_MAX - 1))
                    : (out_ch.sjw_code == out_ch.seg2_code[SJW_W-1:0]);

  // Checks on the sequencer and on the result encoding.
  `CBTS_CHECK_NEXT(a_busy_after_req, in_req, !in_ch.ready, "ready after request")
  `CBTS_CHECK(a_miss_zero, res_miss, res_zero, "nonzero fields without a solution")
  `CBTS_CHECK(a_seg_order, res_hit, seg_ok, "segment 1 shorter than segment 2")
  `CBTS_CHECK(a_sjw_code, res_hit, sjw_ok, "SJW code does not follow segment 2")

endmodule

@@ tb/can_bit_timing_search_top_test.sv @@
`timescale 1ns / 1ps

module can_bit_timing_search_top_test;
  import cbts_pkg::*;

  // One timing solution as it leaves the block.
  typedef struct packed {
    logic             found;
    logic [PRE_W-1:0] prescaler;
    logic [S1C_W-1:0] seg1_code;
    logic [S2C_W-1:0] seg2_code;
    logic [SJW_W-1:0] sjw_code;
  } timing_t;

  // One row of the directed part: an optional clock change, then one request.
  typedef struct {
    bit                set_clk;
    logic [CLK_W-1:0]  pclk;
    logic [RATE_W-1:0] rate;
    bit                known;
    timing_t           want;
  } row_t;

  localparam timing_t           NOT_FOUND       = '0;
  localparam logic [CFG_AW-1:0] PCLK_ADDR       = {REG_PCLK, 2'b00};
  localparam int                HOLD_CYCLES     = 3000;
  localparam int                TAIL_CYCLES     = 20000;
  localparam int                WATCHDOG_LIMIT  = 100000;
  localparam int                RANDOM_PHASES   = 4;
  localparam int                RATES_PER_PHASE = 20;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  cbts_in_if  in_ch ();
  cbts_out_if out_ch ();

  can_bit_timing_search_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the clock register and the solutions still owed by the block.
  logic [CLK_W-1:0] pclk_model;
  timing_t          pending_timings[$];

  int unsigned mismatches     = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned found_seen     = 0;
  int unsigned clock_settings = 0;
  int unsigned quiet_cycles   = 0;
  bit          steady         = 1'b0;
  bit          hold_pending   = 1'b0;

  // Directed requests: extremes, special cases and the common CAN rates.
  row_t directed_rows [22] = '{
    '{1'b0, 32'd0, 20'd0, 1'b1, NOT_FOUND},
    '{1'b0, 32'd0, 20'd1, 1'b1, NOT_FOUND},
    '{1'b0, 32'd0, 20'd1000000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd500000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd250000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd125000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd83333, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd50000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd10000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'hFFFFF, 1'b0, NOT_FOUND},
    '{1'b1, 32'd0, 20'd500000, 1'b1, NOT_FOUND},
    '{1'b0, 32'd0, 20'd0, 1'b1, NOT_FOUND},
    '{1'b1, 32'd1, 20'd1, 1'b0, NOT_FOUND},
    '{1'b1, 32'hFFFFFFFF, 20'd1, 1'b1, NOT_FOUND},
    '{1'b0, 32'd0, 20'd1000000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'hFFFFF, 1'b0, NOT_FOUND},
    '{1'b1, 32'd8000000, 20'd125000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd1000000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd100000, 1'b0, NOT_FOUND},
    '{1'b1, 32'd80000000, 20'd1000000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd500000, 1'b0, NOT_FOUND},
    '{1'b0, 32'd0, 20'd33333, 1'b0, NOT_FOUND}
  };

  // Requests sent while the receiver holds off; zero rates fill the block fast.
  logic [RATE_W-1:0] pressure_rates [6] = '{20'd0, 20'd0, 20'd0, 20'd125000, 20'd0, 20'd1000000};

  int unsigned can_rates [10] = '{10000, 20000, 50000, 83333, 100000, 125000, 250000,
                                  500000, 800000, 1000000};

  logic [CLK_W-1:0] phase_clocks [RANDOM_PHASES] = '{32'd16000000, 32'd36000000,
                                                     32'd40000000, 32'd48000000};

  always #1 clk = ~clk;

  // Search every segment pair and nearby prescaler for the best timing.
  function automatic timing_t search_timing(input logic [CLK_W-1:0] pclk,
                                            input logic [RATE_W-1:0] rate);
    timing_t         best;
    bit              have;
    int unsigned     best_rerr, best_sperr, tol, nq, sp, sperr, rerr, actual;
    longint unsigned est, lo, hi, p;
    best       = NOT_FOUND;
    have       = 1'b0;
    best_rerr  = 0;
    best_sperr = 0;
    tol        = rate >> RATE_TOL_SHIFT;
    if (rate != 0) begin
      for (int s2 = 1; s2 <= SEG2_MAX_DEF; s2++) begin
        for (int s1 = s2; s1 <= SEG1_MAX_DEF; s1++) begin
          nq  = s1 + s2 + 1;
          est = 64'(pclk) / (64'(nq) * 64'(rate));
          lo  = (est > 1) ? est - 1 : 1;
          hi  = (est < PRESCALER_MAX_DEF) ? est + 1 : PRESCALER_MAX_DEF;
          for (p = lo; p <= hi; p++) begin
            actual = 32'(64'(pclk) / (64'(nq) * p));
            rerr   = (actual > rate) ? actual - rate : rate - actual;
            sp     = ((s1 + 1) << SP_SHIFT) / nq;
            sperr  = (sp > SP_TARGET) ? sp - SP_TARGET : SP_TARGET - sp;
            // Ties replace the held candidate; a worse error in either term does not.
            if (rerr <= tol && sperr <= SP_TOLERANCE &&
                !(have && (sperr > best_sperr || rerr > best_rerr))) begin
              have           = 1'b1;
              best.found     = 1'b1;
              best.prescaler = PRE_W'(p);
              best.seg1_code = S1C_W'(s1 - 1);
              best.seg2_code = S2C_W'(s2 - 1);
              best.sjw_code  = (s2 <= SJW_MAX) ? SJW_W'(s2 - 1) : SJW_W'(SJW_MAX - 1);
              best_rerr      = rerr;
              best_sperr     = sperr;
            end
          end
        end
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s at %0t: got %0d, expected %0d", what, $time, got, want);
    mismatches++;
  endtask

  // Read the clock register and compare it with the value it should hold.
  task automatic check_clock_reg(input logic [CLK_W-1:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= PCLK_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      report_mismatch("clock register readback", prdata, want);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the clock register, then read it back.
  task automatic program_clock(input logic [CLK_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PCLK_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    pclk_model = value;
    clock_settings++;
    @(posedge clk);
    check_clock_reg(value);
  endtask

  // Offer one request, with random gaps before it unless the run is steady.
  task automatic send_rate(input logic [RATE_W-1:0] rate, input bit known,
                           input timing_t typed);
    while (!steady && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.bit_rate <= rate;
    do @(posedge clk); while (!in_ch.ready);
    pending_timings.push_back(known ? typed : search_timing(pclk_model, rate));
    requests_sent++;
  endtask

  // Stop offering and wait until every result is in and the block is idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_timings.size() != 0 || !in_ch.ready);
  endtask

  // Result side: random stalls, one long hold-off on request, steady stretches.
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 13);
      end
    end
  end

  // Compare each accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    timing_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_timings.size() == 0) begin
        report_mismatch("result with no request pending", 1, 0);
      end else begin
        want = pending_timings.pop_front();
        if (out_ch.found !== want.found) begin
          report_mismatch("found", out_ch.found, want.found);
        end
        if (out_ch.prescaler !== want.prescaler) begin
          report_mismatch("prescaler", out_ch.prescaler, want.prescaler);
        end
        if (out_ch.seg1_code !== want.seg1_code) begin
          report_mismatch("seg1_code", out_ch.seg1_code, want.seg1_code);
        end
        if (out_ch.seg2_code !== want.seg2_code) begin
          report_mismatch("seg2_code", out_ch.seg2_code, want.seg2_code);
        end
        if (out_ch.sjw_code !== want.sjw_code) begin
          report_mismatch("sjw_code", out_ch.sjw_code, want.sjw_code);
        end
        results_seen++;
        if (want.found) begin
          found_seen++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", quiet_cycles);
      $display("can_bit_timing_search_top_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned       base;
    int unsigned       pick;
    logic [RATE_W-1:0] rate;
    in_ch.valid    = 1'b0;
    in_ch.bit_rate = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_n          = 1'b0;
    pclk_model     = CLK_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The clock register comes out of reset at 36 MHz.
    check_clock_reg(CLK_RESET);

    // Directed part.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_clk) begin
        drain();
        program_clock(directed_rows[i].pclk);
      end
      send_rate(directed_rows[i].rate, directed_rows[i].known, directed_rows[i].want);
    end

    // Back-pressure: the receiver holds off while requests keep coming.
    drain();
    program_clock(CLK_RESET);
    hold_pending = 1'b1;
    foreach (pressure_rates[i]) begin
      send_rate(pressure_rates[i], 1'b0, NOT_FOUND);
    end

    // Random part: mostly common CAN rates with a little jitter, plus zero rates and noise.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      program_clock((ph == RANDOM_PHASES - 1) ? CLK_W'($urandom) : phase_clocks[ph]);
      steady = (ph == 1);
      for (int n = 0; n < RATES_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          rate = '0;
        end else if (pick < 75) begin
          base = can_rates[$urandom_range(9)];
          rate = RATE_W'(base - (base >> 7) + $urandom_range(base >> 6));
        end else begin
          rate = RATE_W'($urandom);
        end
        send_rate(rate, 1'b0, NOT_FOUND);
      end
    end
    steady = 1'b0;

    // Let any stray result show up before the verdict.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d bit rate requests (%0d with a timing found) over %0d clock settings.",
             results_seen, found_seen, clock_settings);
    $display("Included zero rate and zero clock, prescaler overflow and a long receiver stall.");
    if (mismatches == 0) begin
      $display("can_bit_timing_search_top_test OK");
    end else begin
      $display("can_bit_timing_search_top_test NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cbts_pkg.sv
hw/rtl/cbts_if.sv
hw/rtl/cbts_div.sv
hw/rtl/can_bit_timing_search_top.sv
tb/can_bit_timing_search_top_test.sv
